@@ rtl/core/fjot_pkg.sv @@
// ----------------------------------------------------------------------------
// fjot_pkg
// Types, codes and helpers shared by the flat object tokenizer modules.
// ----------------------------------------------------------------------------
package fjot_pkg;

	localparam int HOLD_DEPTH_DEF = 16;

	// result kinds
	localparam logic [2:0] K_KEY    = 3'd0;
	localparam logic [2:0] K_VAL    = 3'd1;
	localparam logic [2:0] K_PAIR   = 3'd2;
	localparam logic [2:0] K_ACCEPT = 3'd3;
	localparam logic [2:0] K_REJECT = 3'd4;
	localparam logic [2:0] K_OVERFL = 3'd5;

	// characters of interest
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [3:0] {
		PH_START,
		PH_OPENED,
		PH_KEY,
		PH_KEY_ESC,
		PH_AFTER_KEY,
		PH_BEFORE_VAL,
		PH_VAL_Q,
		PH_VAL_ESC,
		PH_BARE,
		PH_AFTER_VAL,
		PH_AFTER_COMMA,
		PH_TRAIL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		CS_RUN,
		CS_FL_RD,
		CS_FL_WR,
		CS_FL_LAST
	} ctrl_state_t;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_BYTE,
		SEL_ESC,
		SEL_HELD,
		SEL_PEND
	} byte_sel_t;

	typedef struct packed {
		logic       end_of_text;
		logic       is_space;
		logic       is_lbrace;
		logic       is_rbrace;
		logic       is_colon;
		logic       is_comma;
		logic       is_quote;
		logic       is_bslash;
		logic       esc_ok;
		logic       cnt_zero;
		logic       cnt_full;
		logic       flush_last;
		logic       out_free;
	} dp_status_t;

	typedef struct packed {
		logic       emit;
		logic [2:0] kind;
		byte_sel_t  sel;
		logic       last;
		logic       push;
		logic       clr_count;
		logic       latch_pend;
		logic       ptr_clr;
		logic       ptr_inc;
	} dp_cmd_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// decoded escape character; valid flag low for a bad escape
	function automatic logic [8:0] unescape(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, c};
			CH_N:                          r = {1'b1, CH_LF};
			CH_T:                          r = {1'b1, CH_TAB};
			default:                       r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/fjot_if.sv @@
// ----------------------------------------------------------------------------
// fjot_in_if / fjot_out_if
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface fjot_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface fjot_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] token_byte;
	logic       last_of_run;

	modport source (output valid, output token_kind, output token_byte,
		output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_byte,
		input last_of_run, output ready);
endinterface

@@ rtl/core/fjot_dp.sv @@
// ----------------------------------------------------------------------------
// fjot_dp
// Datapath: character decode, whitespace hold memory, output register.
// ----------------------------------------------------------------------------
module fjot_dp
	import fjot_pkg::*;
#(
	parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  dp_cmd_t    cmd,
	output dp_status_t st,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] token_kind,
	output logic [7:0] token_byte,
	output logic       last_of_run
);

	localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
	localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

	logic [7:0]       mem [HOLD_DEPTH];
	logic [7:0]       mem_rd_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] ptr_q;
	logic [7:0]       pend_q;
	logic             valid_q;
	logic [2:0]       kind_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [8:0]       esc;
	logic [7:0]       byte_nxt;

	assign esc = unescape(text_byte);

	always_comb begin
		st.end_of_text = end_of_text;
		st.is_space    = is_space(text_byte);
		st.is_lbrace   = text_byte == CH_LBRACE;
		st.is_rbrace   = text_byte == CH_RBRACE;
		st.is_colon    = text_byte == CH_COLON;
		st.is_comma    = text_byte == CH_COMMA;
		st.is_quote    = text_byte == CH_QUOTE;
		st.is_bslash   = text_byte == CH_BSLASH;
		st.esc_ok      = esc[8];
		st.cnt_zero    = count_q == '0;
		st.cnt_full    = count_q >= CNT_W'(HOLD_DEPTH);
		st.flush_last  = (CNT_W'(ptr_q) + CNT_W'(1)) == count_q;
		st.out_free    = !valid_q || out_ready;
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_BYTE: byte_nxt = text_byte;
			SEL_ESC:  byte_nxt = esc[7:0];
			SEL_HELD: byte_nxt = mem_rd_q;
			SEL_PEND: byte_nxt = pend_q;
			default:  byte_nxt = 8'd0;
		endcase
	end

	// hold memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[IDX_W-1:0]] <= text_byte;
		end
		mem_rd_q <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_pend) begin
			pend_q <= text_byte;
		end
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			byte_q <= byte_nxt;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign token_kind  = kind_q;
	assign token_byte  = byte_q;
	assign last_of_run = last_q;

endmodule

@@ rtl/core/fjot_ctrl.sv @@
// ----------------------------------------------------------------------------
// fjot_ctrl
// Controller: parse phase, input handshake and whitespace flush sequencing.
// ----------------------------------------------------------------------------
module fjot_ctrl
	import fjot_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	phase_t      phase_q, phase_nxt;
	ctrl_state_t cs_q, cs_nxt;

	function automatic dp_cmd_t emit_cmd(input logic [2:0] kind, input byte_sel_t sel);
		dp_cmd_t c;
		c      = '0;
		c.emit = 1'b1;
		c.kind = kind;
		c.sel  = sel;
		c.last = 1'b1;
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cs_q    <= CS_RUN;
		end else begin
			phase_q <= phase_nxt;
			cs_q    <= cs_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		phase_nxt = phase_q;
		cs_nxt    = cs_q;
		in_ready  = (cs_q == CS_RUN) && st.out_free;
		unique case (cs_q)
			CS_RUN: begin
				if (in_valid && in_ready) begin
					if (st.end_of_text) begin
						if (phase_q == PH_TRAIL) begin
							cmd = emit_cmd(K_ACCEPT, SEL_ZERO);
						end else if (phase_q != PH_DONE) begin
							cmd = emit_cmd(K_REJECT, SEL_ZERO);
						end
						cmd.clr_count = 1'b1;
						phase_nxt     = PH_START;
					end else begin
						unique case (phase_q)
							PH_START: begin
								if (st.is_lbrace) begin
									phase_nxt = PH_OPENED;
								end else if (!st.is_space) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_OPENED: begin
								if (st.is_rbrace) begin
									phase_nxt = PH_TRAIL;
								end else if (st.is_quote) begin
									phase_nxt = PH_KEY;
								end else if (!st.is_space) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_KEY: begin
								if (st.is_quote) begin
									phase_nxt = PH_AFTER_KEY;
								end else if (st.is_bslash) begin
									phase_nxt = PH_KEY_ESC;
								end else begin
									cmd = emit_cmd(K_KEY, SEL_BYTE);
								end
							end
							PH_KEY_ESC: begin
								if (st.esc_ok) begin
									cmd       = emit_cmd(K_KEY, SEL_ESC);
									phase_nxt = PH_KEY;
								end else begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_AFTER_KEY: begin
								if (st.is_colon) begin
									phase_nxt = PH_BEFORE_VAL;
								end else if (!st.is_space) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_BEFORE_VAL: begin
								if (st.is_quote) begin
									phase_nxt = PH_VAL_Q;
								end else if (st.is_comma || st.is_rbrace) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end else if (!st.is_space) begin
									cmd           = emit_cmd(K_VAL, SEL_BYTE);
									cmd.clr_count = 1'b1;
									phase_nxt     = PH_BARE;
								end
							end
							PH_VAL_Q: begin
								if (st.is_quote) begin
									cmd       = emit_cmd(K_PAIR, SEL_ZERO);
									phase_nxt = PH_AFTER_VAL;
								end else if (st.is_bslash) begin
									phase_nxt = PH_VAL_ESC;
								end else begin
									cmd = emit_cmd(K_VAL, SEL_BYTE);
								end
							end
							PH_VAL_ESC: begin
								if (st.esc_ok) begin
									cmd       = emit_cmd(K_VAL, SEL_ESC);
									phase_nxt = PH_VAL_Q;
								end else begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_BARE: begin
								if (st.is_comma || st.is_rbrace) begin
									cmd           = emit_cmd(K_PAIR, SEL_ZERO);
									cmd.clr_count = 1'b1;
									phase_nxt     = st.is_comma ? PH_AFTER_COMMA : PH_TRAIL;
								end else if (st.is_space) begin
									if (st.cnt_full) begin
										cmd = emit_cmd(K_OVERFL, SEL_ZERO);
									end else begin
										cmd.push = 1'b1;
									end
								end else if (st.cnt_zero) begin
									cmd = emit_cmd(K_VAL, SEL_BYTE);
								end else begin
									// held whitespace goes out ahead of this byte
									cmd.latch_pend = 1'b1;
									cmd.ptr_clr    = 1'b1;
									cs_nxt         = CS_FL_RD;
								end
							end
							PH_AFTER_VAL: begin
								if (st.is_comma) begin
									phase_nxt = PH_AFTER_COMMA;
								end else if (st.is_rbrace) begin
									phase_nxt = PH_TRAIL;
								end else if (!st.is_space) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_AFTER_COMMA: begin
								if (st.is_quote) begin
									phase_nxt = PH_KEY;
								end else if (!st.is_space) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							PH_TRAIL: begin
								if (!st.is_space) begin
									cmd = emit_cmd(K_REJECT, SEL_ZERO);
								end
							end
							default: begin
								phase_nxt = PH_DONE;
							end
						endcase
						// any verdict ends the text until the end marker
						if (cmd.emit && (cmd.kind == K_REJECT || cmd.kind == K_OVERFL)) begin
							cmd.clr_count = 1'b1;
							phase_nxt     = PH_DONE;
						end
					end
				end
			end
			CS_FL_RD: begin
				// memory read data lands at the end of this cycle
				cs_nxt = CS_FL_WR;
			end
			CS_FL_WR: begin
				if (st.out_free) begin
					cmd         = emit_cmd(K_VAL, SEL_HELD);
					cmd.last    = 1'b0;
					cmd.ptr_inc = 1'b1;
					cs_nxt      = st.flush_last ? CS_FL_LAST : CS_FL_RD;
				end
			end
			CS_FL_LAST: begin
				if (st.out_free) begin
					cmd           = emit_cmd(K_VAL, SEL_PEND);
					cmd.clr_count = 1'b1;
					cs_nxt        = CS_RUN;
				end
			end
			default: begin
				cs_nxt = CS_RUN;
			end
		endcase
	end

endmodule

@@ rtl/core/flat_json_object_tokenizer.sv @@
// Throughput: one item per cycle while the sink keeps up; a result is
// registered as its item is accepted, but a byte ending held whitespace in a
// bare value stalls the input and goes out after the held bytes, each read
// then written, paced by the single read port and one-entry output register.
// Reset: asynchronous, clears the parse phase, hold count and output valid;
// the hold memory is not cleared; only entries below the hold count are used.
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer
// Streaming tokenizer and checker for a flat object of quoted keys and values.
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer
	import fjot_pkg::*;
#(
	parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fjot_in_if.sink    text_in,
	fjot_out_if.source token_out
);

	dp_status_t st;
	dp_cmd_t    cmd;

	fjot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	fjot_dp #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_in.text_byte),
		.end_of_text (text_in.end_of_text),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (token_out.valid),
		.out_ready   (token_out.ready),
		.token_kind  (token_out.token_kind),
		.token_byte  (token_out.token_byte),
		.last_of_run (token_out.last_of_run)
	);

endmodule
